// ----- design/rks_pkg.sv -----
// Shared types, constants and the digit picker of the record key radix sorter.
package rks_pkg;

  localparam int MAX_RECORDS_DEF = 1024;
  localparam int KEY_BYTES_DEF   = 10;
  localparam int KEY_BYTES_MAX   = 10;
  localparam int BYTE_W          = 4;
  localparam int DIGIT_W         = 8;
  localparam int DIGIT_VALUES    = 256;
  localparam int KEY_HIGH_W      = 16;
  localparam int KEY_LOW_W       = 64;
  localparam int TAG_W           = 10;
  localparam int IN_TDATA_W      = 96;
  localparam int OUT_TDATA_W     = 96;

  localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGIT_VALUES - 1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [TAG_W-1:0]      tag;
    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_HIGH_W-1:0] key_high;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CNT_ADDR,
    ST_CNT_DIG,
    ST_CNT_INC,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_SCT_ADDR,
    ST_SCT_DIG,
    ST_SCT_WR,
    ST_RD_MEM,
    ST_RD_OUT
  } state_e;

  // Key byte b, byte 0 being the most significant of the 80-bit key.
  function automatic logic [DIGIT_W-1:0] digit_of(rec_t r, logic [BYTE_W-1:0] b);
    logic [KEY_HIGH_W+KEY_LOW_W-1:0] k;
    logic [DIGIT_W-1:0]              d;
    k = {r.key_high, r.key_low};
    d = '0;
    for (int j = 0; j < KEY_BYTES_MAX; j++) begin
      if (b == BYTE_W'(j)) begin
        d = k[DIGIT_W*(KEY_BYTES_MAX-1-j) +: DIGIT_W];
      end
    end
    return d;
  endfunction

endpackage

// ----- design/record_key_radix_sorter_unit.sv -----
// Top level of the record key radix sorter: load, ten-pass LSD radix sort, sorted readout.
//
//  channel  dir  handshake                 content
//  s_axis   in   s_axis_tvalid/tready      load or read command with one record
//  m_axis   out  m_axis_tvalid/tready      one readout item per read command
//
// A load with tlast starts the sort, during which the block takes no item:
// each key byte pass clears the histogram, counts the digit of every record,
// turns the counts into running offsets by a prefix scan and scatters every
// record to its offset in the other store. A read goes through ST_RD_MEM and
// ST_RD_OUT and waits there while the output register still holds an untaken item.
// Reset clears control state only; the stores hold garbage until loaded.
module record_key_radix_sorter_unit #(
  parameter int MAX_RECORDS = rks_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BYTES   = rks_pkg::KEY_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // key_high_in[15:0], key_low_in[79:16], tag_in[89:80], zero pad
  input  logic [rks_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  // last_load
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // key_high_out[15:0], key_low_out[79:16], tag_out[89:80], overflow_seen[90], zero pad
  output logic [rks_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // record_valid
  output logic                             m_axis_tuser,
  // final_record
  output logic                             m_axis_tlast
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);
  localparam logic [rks_pkg::BYTE_W-1:0] FIRST_BYTE = rks_pkg::BYTE_W'(KEY_BYTES - 1);

  rks_pkg::state_e state_q, state_d;

  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   rp_q, rp_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   run_q, run_d;
  logic [rks_pkg::DIGIT_W-1:0]     dig_q, dig_d;
  logic [rks_pkg::BYTE_W-1:0]      byte_q, byte_d;
  logic                            src_spare_q, src_spare_d;
  logic                            res_spare_q, res_spare_d;
  logic                            sorted_q, sorted_d;
  logic                            ovf_q, ovf_d;

  logic                            out_valid_q, out_valid_d;
  rks_pkg::rec_t                   out_rec_q, out_rec_d;
  logic                            out_recv_q, out_recv_d;
  logic                            out_final_q, out_final_d;
  logic                            out_ovf_q, out_ovf_d;

  logic                            in_acc;
  rks_pkg::rec_t                   in_rec;
  logic [CW-1:0]                   eff_count;
  logic                            reading;
  logic                            out_free;
  logic                            rec_avail;

  logic [AW-1:0]                   st_raddr;
  rks_pkg::rec_t                   prim_rd, spare_rd, cur_rec;
  logic                            prim_we, spare_we;
  logic [AW-1:0]                   prim_waddr, spare_waddr;
  rks_pkg::rec_t                   prim_wdata, spare_wdata;

  logic [rks_pkg::DIGIT_W-1:0]     cur_digit;
  logic                            hist_we;
  logic [rks_pkg::DIGIT_W-1:0]     hist_waddr, hist_raddr;
  logic [CW-1:0]                   hist_wdata, hist_rd;

  assign s_axis_tready = (state_q == rks_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_rec.key_high = s_axis_tdata[15:0];
  assign in_rec.key_low  = s_axis_tdata[79:16];
  assign in_rec.tag      = s_axis_tdata[89:80];

  assign eff_count = sorted_q ? '0 : count_q;
  assign reading   = (state_q == rks_pkg::ST_RD_MEM) || (state_q == rks_pkg::ST_RD_OUT);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign rec_avail = sorted_q && (rp_q < count_q);

  assign st_raddr  = reading ? rp_q[AW-1:0] : idx_q[AW-1:0];
  assign cur_rec   = (reading ? res_spare_q : src_spare_q) ? spare_rd : prim_rd;
  assign cur_digit = rks_pkg::digit_of(cur_rec, byte_q);

  rks_ram #(.WIDTH(rks_pkg::REC_W), .DEPTH(MAX_RECORDS)) u_primary (
    .clk_i   (clk_i),
    .we_i    (prim_we),
    .waddr_i (prim_waddr),
    .wdata_i (prim_wdata),
    .raddr_i (st_raddr),
    .rdata_o (prim_rd)
  );

  rks_ram #(.WIDTH(rks_pkg::REC_W), .DEPTH(MAX_RECORDS)) u_spare (
    .clk_i   (clk_i),
    .we_i    (spare_we),
    .waddr_i (spare_waddr),
    .wdata_i (spare_wdata),
    .raddr_i (st_raddr),
    .rdata_o (spare_rd)
  );

  // Histogram, turned in place into running offsets by the prefix scan.
  rks_ram #(.WIDTH(CW), .DEPTH(rks_pkg::DIGIT_VALUES)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rks_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == rks_pkg::CMD_READ) begin
            state_d = rks_pkg::ST_RD_MEM;
          end else if (s_axis_tlast) begin
            state_d = rks_pkg::ST_CLEAR;
          end
        end
      end
      rks_pkg::ST_CLEAR: begin
        if (dig_q == rks_pkg::LAST_DIGIT) begin
          state_d = rks_pkg::ST_CNT_ADDR;
        end
      end
      rks_pkg::ST_CNT_ADDR: begin
        state_d = (idx_q == count_q) ? rks_pkg::ST_SCAN_RD : rks_pkg::ST_CNT_DIG;
      end
      rks_pkg::ST_CNT_DIG:  state_d = rks_pkg::ST_CNT_INC;
      rks_pkg::ST_CNT_INC:  state_d = rks_pkg::ST_CNT_ADDR;
      rks_pkg::ST_SCAN_RD:  state_d = rks_pkg::ST_SCAN_WR;
      rks_pkg::ST_SCAN_WR: begin
        state_d = (dig_q == rks_pkg::LAST_DIGIT) ? rks_pkg::ST_SCT_ADDR : rks_pkg::ST_SCAN_RD;
      end
      rks_pkg::ST_SCT_ADDR: begin
        if (idx_q != count_q) begin
          state_d = rks_pkg::ST_SCT_DIG;
        end else if (byte_q == '0) begin
          state_d = rks_pkg::ST_IDLE;
        end else begin
          state_d = rks_pkg::ST_CLEAR;
        end
      end
      rks_pkg::ST_SCT_DIG:  state_d = rks_pkg::ST_SCT_WR;
      rks_pkg::ST_SCT_WR:   state_d = rks_pkg::ST_SCT_ADDR;
      rks_pkg::ST_RD_MEM:   state_d = rks_pkg::ST_RD_OUT;
      rks_pkg::ST_RD_OUT: begin
        if (out_free) begin
          state_d = rks_pkg::ST_IDLE;
        end
      end
      default: state_d = rks_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and datapath registers.
  always_comb begin
    prim_we     = 1'b0;
    prim_waddr  = hist_rd[AW-1:0];
    prim_wdata  = cur_rec;
    spare_we    = 1'b0;
    spare_waddr = hist_rd[AW-1:0];
    spare_wdata = cur_rec;
    hist_we     = 1'b0;
    hist_waddr  = cur_digit;
    hist_wdata  = hist_rd + CW'(1);
    hist_raddr  = cur_digit;

    count_d     = count_q;
    rp_d        = rp_q;
    idx_d       = idx_q;
    run_d       = run_q;
    dig_d       = dig_q;
    byte_d      = byte_q;
    src_spare_d = src_spare_q;
    res_spare_d = res_spare_q;
    sorted_d    = sorted_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_rec_d   = out_rec_q;
    out_recv_d  = out_recv_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;

    unique case (state_q)
      rks_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser == rks_pkg::CMD_LOAD)) begin
          // A load after a sort drops the sorted set and starts a new one.
          sorted_d = 1'b0;
          rp_d     = '0;
          count_d  = eff_count;
          if (eff_count < MAX_CNT) begin
            prim_we    = 1'b1;
            prim_waddr = eff_count[AW-1:0];
            prim_wdata = in_rec;
            count_d    = eff_count + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            byte_d      = FIRST_BYTE;
            src_spare_d = 1'b0;
            dig_d       = '0;
          end
        end
      end
      rks_pkg::ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = dig_q;
        hist_wdata = '0;
        dig_d      = dig_q + rks_pkg::DIGIT_W'(1);
        idx_d      = '0;
      end
      rks_pkg::ST_CNT_ADDR: begin
        dig_d = '0;
        run_d = '0;
      end
      rks_pkg::ST_CNT_DIG: begin
      end
      rks_pkg::ST_CNT_INC: begin
        hist_we = 1'b1;
        idx_d   = idx_q + CW'(1);
      end
      rks_pkg::ST_SCAN_RD: begin
        hist_raddr = dig_q;
      end
      rks_pkg::ST_SCAN_WR: begin
        hist_raddr = dig_q;
        hist_we    = 1'b1;
        hist_waddr = dig_q;
        hist_wdata = run_q;
        run_d      = run_q + hist_rd;
        dig_d      = dig_q + rks_pkg::DIGIT_W'(1);
        idx_d      = '0;
      end
      rks_pkg::ST_SCT_ADDR: begin
        if (idx_q == count_q) begin
          // Pass done: the destination becomes the next source.
          src_spare_d = !src_spare_q;
          dig_d       = '0;
          if (byte_q == '0) begin
            sorted_d    = 1'b1;
            res_spare_d = !src_spare_q;
            rp_d        = '0;
          end else begin
            byte_d = byte_q - rks_pkg::BYTE_W'(1);
          end
        end
      end
      rks_pkg::ST_SCT_DIG: begin
      end
      rks_pkg::ST_SCT_WR: begin
        hist_we = 1'b1;
        if (src_spare_q) begin
          prim_we    = 1'b1;
          prim_waddr = hist_rd[AW-1:0];
        end else begin
          spare_we = 1'b1;
        end
        idx_d = idx_q + CW'(1);
      end
      rks_pkg::ST_RD_MEM: begin
      end
      rks_pkg::ST_RD_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ovf_d   = ovf_q;
          out_recv_d  = rec_avail;
          if (rec_avail) begin
            out_rec_d   = cur_rec;
            out_final_d = (rp_q + CW'(1) == count_q);
            rp_d        = rp_q + CW'(1);
          end else begin
            out_rec_d   = '0;
            out_final_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rks_pkg::ST_IDLE;
      count_q     <= '0;
      rp_q        <= '0;
      idx_q       <= '0;
      run_q       <= '0;
      dig_q       <= '0;
      byte_q      <= '0;
      src_spare_q <= 1'b0;
      res_spare_q <= 1'b0;
      sorted_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rp_q        <= rp_d;
      idx_q       <= idx_d;
      run_q       <= run_d;
      dig_q       <= dig_d;
      byte_q      <= byte_d;
      src_spare_q <= src_spare_d;
      res_spare_q <= res_spare_d;
      sorted_q    <= sorted_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q   <= out_rec_d;
    out_recv_q  <= out_recv_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_recv_q;
  assign m_axis_tlast  = out_final_q;
  assign m_axis_tdata  = {5'b0, out_ovf_q, out_rec_q.tag, out_rec_q.key_low, out_rec_q.key_high};

endmodule

// ----- design/rks_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
module rks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/sorted_record_checker.sv -----
`timescale 1ns / 100ps
// Checker of the radix sorter: watches both streams, predicts the sorted readout, compares.
module sorted_record_checker #(
  parameter int MAX_RECORDS = rks_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BYTES   = rks_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [rks_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [rks_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast,
  output int                              mismatch_count,
  output int                              results_due
);

  typedef logic [rks_pkg::KEY_HIGH_W+rks_pkg::KEY_LOW_W-1:0] key_t;

  typedef struct packed {
    logic [rks_pkg::KEY_HIGH_W-1:0] key_high;
    logic [rks_pkg::KEY_LOW_W-1:0]  key_low;
    logic [rks_pkg::TAG_W-1:0]      tag;
    logic                           overflow;
    logic                           valid;
    logic                           final_rec;
  } readout_t;

  rks_pkg::rec_t loaded_set[$];
  rks_pkg::rec_t sorted_set[$];
  readout_t      due_readouts[$];
  bit            sorted_phase = 1'b0;
  bit            overflow_seen = 1'b0;
  int            read_pos = 0;
  int            fails = 0;

  // Key bytes below KEY_BYTES take part in the ordering; the rest are ignored.
  function automatic key_t order_key(rks_pkg::rec_t r);
    key_t k;
    k = {r.key_high, r.key_low};
    for (int b = KEY_BYTES; b < rks_pkg::KEY_BYTES_MAX; b++) begin
      k[rks_pkg::DIGIT_W*(rks_pkg::KEY_BYTES_MAX-1-b) +: rks_pkg::DIGIT_W] = '0;
    end
    return k;
  endfunction

  // Stable ascending order: each record goes after every record with a lower key and after every earlier equal key.
  function automatic void rank_loaded_set();
    int pos;
    sorted_set.delete();
    foreach (loaded_set[i]) begin
      pos = sorted_set.size();
      while (pos > 0 && order_key(sorted_set[pos-1]) > order_key(loaded_set[i])) pos--;
      sorted_set.insert(pos, loaded_set[i]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [rks_pkg::KEY_LOW_W-1:0] got,
                                 input logic [rks_pkg::KEY_LOW_W-1:0] want);
    $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin : watch
    rks_pkg::rec_t in_rec;
    rks_pkg::rec_t out_rec;
    readout_t      want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_rec = rks_pkg::rec_t'(s_axis_tdata[rks_pkg::REC_W-1:0]);
        if (s_axis_tuser == rks_pkg::CMD_LOAD) begin
          // a load after a sort starts a new set
          if (sorted_phase) begin
            sorted_phase = 1'b0;
            loaded_set.delete();
            read_pos = 0;
          end
          if (loaded_set.size() < MAX_RECORDS) loaded_set.push_back(in_rec);
          else overflow_seen = 1'b1;
          if (s_axis_tlast) begin
            rank_loaded_set();
            sorted_phase = 1'b1;
            read_pos = 0;
          end
        end else begin
          want = '0;
          want.overflow = overflow_seen;
          if (sorted_phase && read_pos < sorted_set.size()) begin
            want.key_high  = sorted_set[read_pos].key_high;
            want.key_low   = sorted_set[read_pos].key_low;
            want.tag       = sorted_set[read_pos].tag;
            want.valid     = 1'b1;
            want.final_rec = (read_pos + 1 == sorted_set.size());
            read_pos++;
          end
          due_readouts.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_rec = rks_pkg::rec_t'(m_axis_tdata[rks_pkg::REC_W-1:0]);
        if (due_readouts.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[rks_pkg::KEY_LOW_W-1:0], '0);
        end else begin
          want = due_readouts.pop_front();
          if (out_rec.key_high !== want.key_high)
            report_mismatch("key_high", rks_pkg::KEY_LOW_W'(out_rec.key_high),
                            rks_pkg::KEY_LOW_W'(want.key_high));
          if (out_rec.key_low !== want.key_low)
            report_mismatch("key_low", out_rec.key_low, want.key_low);
          if (out_rec.tag !== want.tag)
            report_mismatch("tag", rks_pkg::KEY_LOW_W'(out_rec.tag),
                            rks_pkg::KEY_LOW_W'(want.tag));
          if (m_axis_tdata[rks_pkg::REC_W] !== want.overflow)
            report_mismatch("overflow_seen", rks_pkg::KEY_LOW_W'(m_axis_tdata[rks_pkg::REC_W]),
                            rks_pkg::KEY_LOW_W'(want.overflow));
          if (m_axis_tdata[rks_pkg::OUT_TDATA_W-1:rks_pkg::REC_W+1] !== '0)
            report_mismatch("pad",
                            rks_pkg::KEY_LOW_W'(m_axis_tdata[rks_pkg::OUT_TDATA_W-1:
                                                             rks_pkg::REC_W+1]), '0);
          if (m_axis_tuser !== want.valid)
            report_mismatch("record_valid", rks_pkg::KEY_LOW_W'(m_axis_tuser),
                            rks_pkg::KEY_LOW_W'(want.valid));
          if (m_axis_tlast !== want.final_rec)
            report_mismatch("final_record", rks_pkg::KEY_LOW_W'(m_axis_tlast),
                            rks_pkg::KEY_LOW_W'(want.final_rec));
        end
      end
    end
    mismatch_count <= fails;
    results_due    <= due_readouts.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench top of the radix sorter: clock, reset, load and read stimulus, verdict.
module tb;

  localparam int IDLE_LIMIT     = 300000;
  localparam int RANDOM_ITEMS   = 650;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int BIG_SET        = rks_pkg::MAX_RECORDS_DEF + 2;
  localparam int BIG_READS      = 40;

  typedef logic [rks_pkg::KEY_HIGH_W+rks_pkg::KEY_LOW_W-1:0] key_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_valid;
  logic                            s_axis_tready;
  logic [rks_pkg::IN_TDATA_W-1:0]  s_data;
  logic                            s_user;
  logic                            s_last;
  logic                            m_axis_tvalid;
  logic                            m_ready;
  logic [rks_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;

  int mismatch_count;
  int results_due;
  int item_total = 0;
  int idle_cycles;
  int rx_stall = 0;
  bit rx_hold_req = 1'b0;
  bit steady = 1'b0;

  key_t key_pool[3];
  key_t k_a;
  int set_size, key_mode, set_len, read_count, random_start, r;
  bit closed;

  record_key_radix_sorter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sorted_record_checker #(
    .MAX_RECORDS (rks_pkg::MAX_RECORDS_DEF),
    .KEY_BYTES   (rks_pkg::KEY_BYTES_DEF)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_valid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_data),
    .s_axis_tuser   (s_user),
    .s_axis_tlast   (s_last),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_ready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int stall_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  function automatic key_t make_key(int mode);
    key_t k;
    k = {16'($urandom_range(0, 65535)), $urandom, $urandom};
    if (mode == 1) begin
      k = key_pool[$urandom_range(0, 2)];
    end else if (mode == 2) begin
      // crowd the digits on their edge values
      for (int b = 0; b < rks_pkg::KEY_BYTES_MAX; b++) begin
        case ($urandom_range(0, 3))
          0:       k[rks_pkg::DIGIT_W*b +: rks_pkg::DIGIT_W] = 8'h00;
          1:       k[rks_pkg::DIGIT_W*b +: rks_pkg::DIGIT_W] = 8'hFF;
          2:       k[rks_pkg::DIGIT_W*b +: rks_pkg::DIGIT_W] = 8'h01;
          default: k[rks_pkg::DIGIT_W*b +: rks_pkg::DIGIT_W] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    return k;
  endfunction

  task automatic send_item(input rks_pkg::cmd_e c, input key_t k,
                           input logic [rks_pkg::TAG_W-1:0] tg, input logic lst);
    int            gap;
    rks_pkg::rec_t rec;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    rec.key_high = k[rks_pkg::KEY_HIGH_W+rks_pkg::KEY_LOW_W-1:rks_pkg::KEY_LOW_W];
    rec.key_low  = k[rks_pkg::KEY_LOW_W-1:0];
    rec.tag      = tg;
    s_data  <= {{(rks_pkg::IN_TDATA_W-rks_pkg::REC_W){1'b0}}, rec};
    s_user  <= c;
    s_last  <= lst;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    item_total++;
  endtask

  task automatic load_rec(input key_t k, input logic [rks_pkg::TAG_W-1:0] tg,
                          input logic lst);
    send_item(rks_pkg::CMD_LOAD, k, tg, lst);
  endtask

  // Reads carry random data and a last flag chosen by the caller; the block ignores both.
  task automatic read_rec(input logic lst);
    send_item(rks_pkg::CMD_READ, make_key(0), rks_pkg::TAG_W'($urandom_range(0, 1023)), lst);
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    s_valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // Receiver: random stalls, plus one long hold when asked.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall = RX_HOLD_CYCLES;
      end else if (rx_stall == 0 && !steady && $urandom_range(0, 3) == 0) begin
        rx_stall = stall_len();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = 1'b0;
    s_last  = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: read on an empty block, then a set with edge keys and duplicates, with a read amid the loads
    read_rec(1'b0);
    k_a = 80'h0123_4567_89AB_CDEF_0011;
    load_rec(k_a, 10'd1, 1'b0);
    load_rec('1, 10'h3FF, 1'b0);
    load_rec('0, 10'd0, 1'b0);
    load_rec(k_a, 10'd2, 1'b0);
    read_rec(1'b1);
    load_rec(k_a - 80'd1, 10'd3, 1'b0);
    load_rec(k_a ^ 80'h8000_0000_0000_0000_0000, 10'd4, 1'b1);
    repeat (6) read_rec(1'b0);
    read_rec(1'b0);
    read_rec(1'b1);
    wait_results_done();

    // single record, then keep offering reads against a long receiver hold
    load_rec({16'h0000, 64'hFFFF_FFFF_FFFF_FFFF}, 10'h3FF, 1'b1);
    wait_results_done();
    steady = 1'b1;
    rx_hold_req = 1'b1;
    repeat (8) read_rec(1'b0);
    steady = 1'b0;
    wait_results_done();

    // random sets
    random_start = item_total;
    set_len = 0;
    while (item_total - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      set_size = (r < 5) ? 1 : (r < 70) ? $urandom_range(2, 24) : $urandom_range(25, 60);
      key_mode = $urandom_range(0, 2);
      steady = ($urandom_range(0, 9) == 0);
      for (int p = 0; p < 3; p++) key_pool[p] = make_key(0);
      closed = 1'b0;
      for (int i = 0; i < set_size; i++) begin
        if ($urandom_range(0, 9) == 0) read_rec(1'($urandom_range(0, 1)));
        closed = (i == set_size - 1) && ($urandom_range(0, 11) != 0);
        load_rec(make_key(key_mode),
                 (key_mode == 1) ? rks_pkg::TAG_W'(set_len)
                                 : rks_pkg::TAG_W'($urandom_range(0, 1023)),
                 closed);
        set_len++;
      end
      if (closed) begin
        read_count = ($urandom_range(0, 6) == 0) ? $urandom_range(0, set_len)
                                                   : set_len + $urandom_range(0, 2);
        repeat (read_count) read_rec(1'($urandom_range(0, 1)));
        set_len = 0;
      end
      if ($urandom_range(0, 3) == 0) wait_results_done();
    end
    steady = 1'b0;
    wait_results_done();

    // fill past capacity; the final load is dropped but still starts the sort
    for (int i = 0; i < BIG_SET; i++) begin
      load_rec(make_key((i % 3 == 0) ? 2 : 0), rks_pkg::TAG_W'($urandom_range(0, 1023)),
               i == BIG_SET - 1);
    end
    repeat (BIG_READS) read_rec(1'b0);

    // overflow stays set on a following set
    for (int i = 0; i < 4; i++) load_rec(make_key(2), rks_pkg::TAG_W'(i), i == 3);
    repeat (5) read_rec(1'($urandom_range(0, 1)));
    wait_results_done();
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
